>>> rtl/madt_pkg.sv
package madt_pkg;

  localparam int unsigned CFG_AW = 3;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_EXPIRE = 2'd1;
  localparam logic [1:0] MODE_POLL   = 2'd2;

  localparam logic REG_TPS = 1'b0;

  localparam logic [31:0] TPS_RESET   = 32'd10000000;
  localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now;
    logic [31:0] delay_seconds;
  } in_t;

  typedef struct packed {
    logic [63:0] compare_value;
    logic [15:0] polled_count;
    logic        pending;
    logic        stored;
  } out_t;

endpackage

>>> rtl/madt_apb_regs.sv
module madt_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [madt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output logic [31:0]                 tps
);

  logic [31:0] tps_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == madt_pkg::REG_TPS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= madt_pkg::TPS_RESET;
    end else if (wr_en) begin
      tps_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == madt_pkg::REG_TPS) ? tps_r : 32'd0;
  assign tps = tps_r;

endmodule

>>> rtl/multi_alarm_deadline_table_core.sv
// Each item runs through the states MUL, ADD, SCAN and OUT in that order: a multiply step,
// an add step, one pass over the slot memory with one slot read and one compare per cycle,
// then the result is handed off (held while out_stall is high) and the block re-arms.
// in_stall is high while an item is in flight or its result waits, so no new item is taken
// before the result of the last one has been taken.
// Reset (rst_n, synchronous): slot active bits, fired count and control are cleared,
// ticks_per_second returns to 10000000; slot deadlines are not cleared.
module multi_alarm_deadline_table_core #(
  parameter int unsigned ALARM_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  madt_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output madt_pkg::out_t              out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [madt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int unsigned IW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(ALARM_SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(ALARM_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [63:0]          now_r, now_nxt;
  logic [31:0]          secs_r, secs_nxt;
  logic [63:0]          prod_r, prod_nxt;
  logic [63:0]          deadline_r, deadline_nxt;
  logic [63:0]          best_r, best_nxt;
  logic                 placed_r, placed_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [ALARM_SLOTS-1:0] active_r, active_nxt;
  logic [15:0]          fired_r, fired_nxt;
  logic                 out_valid_r, out_valid_nxt;
  madt_pkg::out_t       out_data_r, out_data_nxt;
  logic [63:0]          rd_r;
  logic [63:0]          mem [ALARM_SLOTS];

  logic [31:0]          tps;
  logic [CW-1:0]        pidx;
  logic                 wr_en;
  logic                 cand_act;
  logic [63:0]          cand;

  madt_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .tps        (tps)
  );

  assign pidx = idx_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    now_nxt       = now_r;
    secs_nxt      = secs_r;
    prod_nxt      = prod_r;
    deadline_nxt  = deadline_r;
    best_nxt      = best_r;
    placed_nxt    = placed_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    fired_nxt     = fired_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    cand_act      = 1'b0;
    cand          = rd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          now_nxt   = in_data.now;
          secs_nxt  = in_data.delay_seconds;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = 64'(secs_r) * 64'(tps);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        deadline_nxt = now_r + prod_r;
        best_nxt     = madt_pkg::NO_DEADLINE;
        placed_nxt   = 1'b0;
        idx_nxt      = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r != '0) begin
          case (mode_r)
            madt_pkg::MODE_SET: begin
              if (!active_r[pidx[IW-1:0]] && !placed_r) begin
                active_nxt[pidx[IW-1:0]] = 1'b1;
                placed_nxt = 1'b1;
                wr_en      = 1'b1;
                cand       = deadline_r;
                cand_act   = 1'b1;
              end else begin
                cand_act = active_r[pidx[IW-1:0]];
              end
            end
            madt_pkg::MODE_EXPIRE: begin
              if (active_r[pidx[IW-1:0]] && (now_r >= rd_r)) begin
                active_nxt[pidx[IW-1:0]] = 1'b0;
                if (fired_r != madt_pkg::COUNT_MAX) begin
                  fired_nxt = fired_r + 16'd1;
                end
              end else begin
                cand_act = active_r[pidx[IW-1:0]];
              end
            end
            default: begin
              cand_act = active_r[pidx[IW-1:0]];
            end
          endcase
          if (cand_act && (cand < best_r)) begin
            best_nxt = cand;
          end
        end
        if (idx_r == LAST) begin
          out_data_nxt.compare_value = best_nxt;
          out_data_nxt.polled_count  = 16'd0;
          out_data_nxt.stored        = placed_nxt;
          if (mode_r == madt_pkg::MODE_POLL) begin
            out_data_nxt.polled_count = fired_r;
            fired_nxt = 16'd0;
          end
          out_data_nxt.pending = (fired_nxt != 16'd0);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      fired_r     <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    now_r      <= now_nxt;
    secs_r     <= secs_nxt;
    prod_r     <= prod_nxt;
    deadline_r <= deadline_nxt;
    best_r     <= best_nxt;
    placed_r   <= placed_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pidx[IW-1:0]] <= deadline_r;
    end
    if ((state_r == ST_SCAN) && (idx_r != LAST)) begin
      rd_r <= mem[idx_r[IW-1:0]];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_stored_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.stored) |-> (mode_r == madt_pkg::MODE_SET))
    else $error("stored flag outside set mode");

  a_polled_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.polled_count != 16'd0)) |-> (mode_r == madt_pkg::MODE_POLL))
    else $error("polled count outside poll mode");

  a_pending_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pending == (fired_r != 16'd0)))
    else $error("pending flag disagrees with fired count");

endmodule

>>> tb/madt_alarm_checker.sv
`timescale 1ns / 1ps

module madt_alarm_checker #(
  parameter int unsigned ALARM_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  madt_pkg::in_t               in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  madt_pkg::out_t              out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [madt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output int                          mismatch_count,
  output int                          results_seen,
  output int                          results_left
);

  localparam logic [madt_pkg::CFG_AW-1:0] ADDR_TPS = {madt_pkg::REG_TPS, 2'b00};

  logic [63:0]    slot_due [ALARM_SLOTS];
  bit             slot_armed [ALARM_SLOTS];
  logic [15:0]    fired_total;
  logic [31:0]    tick_rate;
  madt_pkg::out_t expected_alarm_results [$];
  madt_pkg::out_t want;

  task automatic step_alarm_table(input madt_pkg::in_t item, output madt_pkg::out_t res);
    logic [63:0] due;
    logic [63:0] earliest;
    res = '0;
    case (item.mode)
      madt_pkg::MODE_SET: begin
        due = item.now + 64'(item.delay_seconds) * 64'(tick_rate);
        for (int s = 0; s < ALARM_SLOTS; s++) begin
          if (!slot_armed[s]) begin
            slot_due[s]   = due;
            slot_armed[s] = 1'b1;
            res.stored    = 1'b1;
            break;
          end
        end
      end
      madt_pkg::MODE_EXPIRE: begin
        for (int s = 0; s < ALARM_SLOTS; s++) begin
          if (slot_armed[s] && item.now >= slot_due[s]) begin
            slot_armed[s] = 1'b0;
            if (fired_total != madt_pkg::COUNT_MAX) fired_total++;
          end
        end
      end
      madt_pkg::MODE_POLL: begin
        res.polled_count = fired_total;
        fired_total      = '0;
      end
      default: ;
    endcase
    earliest = madt_pkg::NO_DEADLINE;
    for (int s = 0; s < ALARM_SLOTS; s++) begin
      if (slot_armed[s] && slot_due[s] < earliest) earliest = slot_due[s];
    end
    res.compare_value = earliest;
    res.pending       = (fired_total != 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ALARM_SLOTS; s++) slot_armed[s] = 1'b0;
      fired_total = '0;
      tick_rate   = madt_pkg::TPS_RESET;
      expected_alarm_results.delete();
      results_left <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_TPS)
        tick_rate = cfg_pwdata;
      if (in_valid && !in_stall) begin
        step_alarm_table(in_data, want);
        expected_alarm_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_alarm_results.size() == 0) begin
          $error("unexpected result item: %h", out_data);
          mismatch_count++;
        end else begin
          want = expected_alarm_results.pop_front();
          results_seen++;
          if (out_data.compare_value !== want.compare_value) begin
            $error("compare_value: expected %h, got %h", want.compare_value,
                   out_data.compare_value);
            mismatch_count++;
          end
          if (out_data.polled_count !== want.polled_count) begin
            $error("polled_count: expected %0d, got %0d", want.polled_count,
                   out_data.polled_count);
            mismatch_count++;
          end
          if (out_data.pending !== want.pending) begin
            $error("pending: expected %b, got %b", want.pending, out_data.pending);
            mismatch_count++;
          end
          if (out_data.stored !== want.stored) begin
            $error("stored: expected %b, got %b", want.stored, out_data.stored);
            mismatch_count++;
          end
        end
      end
      results_left <= expected_alarm_results.size();
    end
  end

endmodule

>>> tb/tb_multi_alarm_deadline_table_core.sv
`timescale 1ns / 1ps

module tb_multi_alarm_deadline_table_core;

  localparam logic [1:0]                  MODE_UNUSED     = 2'd3;
  localparam logic [madt_pkg::CFG_AW-1:0] ADDR_TPS        = {madt_pkg::REG_TPS, 2'b00};
  localparam logic [madt_pkg::CFG_AW-1:0] ADDR_IGNORED    = {~madt_pkg::REG_TPS, 2'b00};
  localparam int                          RATE_PHASES     = 6;
  localparam int                          ITEMS_PER_RATE  = 150;
  localparam int                          HOLD_OFF_CYCLES = 400;
  localparam int                          STUCK_LIMIT     = 4000;
  localparam int                          SETTLE_CYCLES   = 40;
  localparam int                          FILL_ROUNDS     = 8;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  madt_pkg::in_t               in_data;
  logic                        out_valid;
  logic                        out_stall;
  madt_pkg::out_t              out_data;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [madt_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0]                 cfg_pwdata;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;

  int          mismatch_count;
  int          results_seen;
  int          results_left;
  int          items_sent;
  int          stuck_cycles;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_req;
  logic [63:0] tick_now;
  logic [31:0] cur_tps;
  logic [31:0] rate_plan [RATE_PHASES];

  multi_alarm_deadline_table_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  madt_alarm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .results_seen   (results_seen),
    .results_left   (results_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !rx_quiet && $urandom_range(99) < 15;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic send_alarm_op(input logic [1:0] mode, input logic [63:0] now,
                               input logic [31:0] secs);
    madt_pkg::in_t item;
    item.mode          = mode;
    item.now           = now;
    item.delay_seconds = secs;
    while (!tx_quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_left != 0);
  endtask

  task automatic write_reg(input logic [madt_pkg::CFG_AW-1:0] addr,
                           input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // mostly coherent traffic against a moving tick counter, some noise
  task automatic send_random_op();
    int          pick;
    logic [31:0] secs;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(9))
        0:       secs = $urandom;
        1:       secs = '0;
        default: secs = $urandom_range(8);
      endcase
      send_alarm_op(madt_pkg::MODE_SET, tick_now, secs);
    end else if (pick < 78) begin
      tick_now += 64'(cur_tps) * $urandom_range(3) + $urandom_range(1000);
      send_alarm_op(madt_pkg::MODE_EXPIRE, tick_now, $urandom);
    end else if (pick < 92) begin
      send_alarm_op(madt_pkg::MODE_POLL, tick_now, $urandom);
    end else if (pick < 96) begin
      send_alarm_op(MODE_UNUSED, {$urandom, $urandom}, $urandom);
    end else begin
      tick_now = {$urandom, $urandom};
      send_alarm_op(madt_pkg::MODE_EXPIRE,
                    $urandom_range(1) ? madt_pkg::NO_DEADLINE : tick_now, $urandom);
    end
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    stuck_cycles = 0;
    cur_tps     = madt_pkg::TPS_RESET;
    rate_plan[0] = 32'd1;
    rate_plan[1] = 32'd0;
    rate_plan[2] = 32'hFFFF_FFFF;
    rate_plan[3] = madt_pkg::TPS_RESET;
    rate_plan[4] = $urandom;
    rate_plan[5] = $urandom_range(100, 2);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unused mode, wrap, fill to overflow, expire, poll
    send_alarm_op(madt_pkg::MODE_POLL, '0, '0);
    send_alarm_op(MODE_UNUSED, {$urandom, $urandom}, $urandom);
    send_alarm_op(madt_pkg::MODE_EXPIRE, madt_pkg::NO_DEADLINE, '0);
    send_alarm_op(madt_pkg::MODE_SET, '0, '0);
    send_alarm_op(madt_pkg::MODE_SET, madt_pkg::NO_DEADLINE, 32'hFFFF_FFFF);
    send_alarm_op(madt_pkg::MODE_SET, 64'd100, 32'd1);
    for (int k = 0; k < 14; k++) begin
      send_alarm_op(madt_pkg::MODE_SET, 64'(k) * 64'd1000, 32'(k));
    end
    send_alarm_op(madt_pkg::MODE_EXPIRE, '0, '0);
    send_alarm_op(madt_pkg::MODE_POLL, '0, '0);
    send_alarm_op(madt_pkg::MODE_EXPIRE, madt_pkg::NO_DEADLINE, 32'hFFFF_FFFF);
    send_alarm_op(madt_pkg::MODE_POLL, madt_pkg::NO_DEADLINE, '0);

    for (int p = 0; p < RATE_PHASES; p++) begin
      drain_results();
      if (p == 0) write_reg(ADDR_IGNORED, $urandom);
      write_reg(ADDR_TPS, rate_plan[p]);
      cur_tps  = rate_plan[p];
      tx_quiet = (p == 1);
      rx_quiet = (p == 1);
      if (p == 3) hold_req = 1'b1;
      if (p == 0) tick_now = '0;
      else if (p == 2) tick_now = madt_pkg::NO_DEADLINE - 64'd20000;
      else tick_now = {$urandom, $urandom};
      for (int k = 0; k < ITEMS_PER_RATE; k++) send_random_op();
    end

    // zero rate puts every deadline at now: fill the table, fire it all at once
    drain_results();
    write_reg(ADDR_TPS, '0);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_alarm_op(madt_pkg::MODE_EXPIRE, madt_pkg::NO_DEADLINE, '0);
    send_alarm_op(madt_pkg::MODE_POLL, '0, '0);
    for (int r = 0; r < FILL_ROUNDS; r++) begin
      for (int s = 0; s < 16; s++) send_alarm_op(madt_pkg::MODE_SET, '0, $urandom);
      send_alarm_op(madt_pkg::MODE_EXPIRE, {$urandom, $urandom}, $urandom);
    end
    send_alarm_op(madt_pkg::MODE_POLL, '0, '0);
    send_alarm_op(madt_pkg::MODE_POLL, '0, '0);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items, %0d results checked, over %0d tick rates plus reset rate",
             items_sent, results_seen, RATE_PHASES + 1);
    $display("Covered full table, deadline wrap, zero rate, unused mode, mass expiry");
    if (mismatch_count == 0 && results_left == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/madt_pkg.sv
rtl/madt_apb_regs.sv
rtl/multi_alarm_deadline_table_core.sv
tb/madt_alarm_checker.sv
tb/tb_multi_alarm_deadline_table_core.sv
